### rtl/mqp_pkg.sv
// Shared types and constants for the message queue port.
package mqp_pkg;

    localparam int SLOTS_DEF     = 16;
    localparam int MSG_BYTES_DEF = 256;

    localparam int WORD_W     = 32;
    localparam int LEN_W      = 9;
    localparam int CNT_W      = 5;
    localparam int STAT_W     = 2;
    localparam int SLOT_IDX_W = 8;
    localparam int WORD_IDX_W = 6;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;

    localparam int CMD_DEPTH = 4;
    localparam int OUT_DEPTH = 4;

    localparam logic [CFG_IDX_W-1:0] CFG_MAX_MESSAGES      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_MESSAGE_BYTES = 2'd1;

    localparam logic [CNT_W-1:0] MAX_MESSAGES_RST      = 5'd16;
    localparam logic [LEN_W-1:0] MAX_MESSAGE_BYTES_RST = 9'd256;

    localparam logic [STAT_W-1:0] ST_NO_ERROR       = 2'd0;
    localparam logic [STAT_W-1:0] ST_NOT_AVAILABLE  = 2'd1;
    localparam logic [STAT_W-1:0] ST_INVALID_CONFIG = 2'd2;

    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_READ  = 1'b1;

    typedef struct packed {
        logic              cmd;
        logic [LEN_W-1:0]  length_bytes;
        logic [WORD_W-1:0] data_word;
        logic              last_beat;
    } t_item;

    typedef struct packed {
        logic [STAT_W-1:0] status;
        logic [WORD_W-1:0] read_word;
        logic [LEN_W-1:0]  read_length;
        logic              last_result;
        logic [CNT_W-1:0]  queue_count;
    } t_result;

    typedef struct packed {
        logic                  valid;
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } t_cfg_wr;

    typedef struct packed {
        logic                  is_read;
        logic                  store_word;
        logic                  store_len;
        logic [SLOT_IDX_W-1:0] slot;
        logic [WORD_IDX_W-1:0] word_idx;
        logic [WORD_W-1:0]     data;
        logic [LEN_W-1:0]      length;
        logic [STAT_W-1:0]     status;
        logic [CNT_W-1:0]      count;
    } t_cmd;

endpackage

### rtl/message_queue_port.sv
// Top level of the message queue port: front end, command queue, back end, result queue.
// Write beat: accepted one per cycle unless the command queue is full; its result goes
// through the command queue and the back end into the result queue. Read: the back end
// fetches the length, sets up, then streams one word per cycle while the result queue has room.
// Write beats and empty reads push a single result; a full result queue stalls the stream.
// Reset is synchronous: queue empty, registers at defaults; slot RAMs are not cleared.
module message_queue_port #(
    parameter int SLOTS             = mqp_pkg::SLOTS_DEF,
    parameter int MAX_MESSAGE_BYTES = mqp_pkg::MSG_BYTES_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             push,
    input  mqp_pkg::t_item                   i_item,
    output logic                             full,
    output logic                             empty,
    input  logic                             pop,
    output mqp_pkg::t_result                 o_result,
    input  logic                             i_cfg_valid,
    output logic                             o_cfg_ready,
    input  logic [mqp_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [mqp_pkg::CFG_DATA_W-1:0]   i_cfg_data
);

    import mqp_pkg::*;

    localparam int OCW = $clog2(OUT_DEPTH + 1);

    t_cfg_wr          cfg;
    logic             cmd_push, cmd_pop, cmd_empty;
    t_cmd             cmd_in, cmd_out;
    logic             out_push, out_full;
    t_result          out_in;
    logic [OCW-1:0]   out_count;

    assign o_cfg_ready = 1'b1;
    assign cfg.valid   = i_cfg_valid;
    assign cfg.index   = i_cfg_index;
    assign cfg.data    = i_cfg_data;

    mqp_front #(
        .SLOTS             (SLOTS),
        .MAX_MESSAGE_BYTES (MAX_MESSAGE_BYTES)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg      (cfg),
        .i_push     (push),
        .i_item     (i_item),
        .i_cmd_full (full),
        .o_cmd_push (cmd_push),
        .o_cmd      (cmd_in)
    );

    mqp_fifo #(
        .WIDTH ($bits(t_cmd)),
        .DEPTH (CMD_DEPTH)
    ) u_cmd_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (cmd_push),
        .i_data  (cmd_in),
        .o_full  (full),
        .i_pop   (cmd_pop),
        .o_data  (cmd_out),
        .o_empty (cmd_empty),
        .o_count ()
    );

    mqp_back #(
        .SLOTS             (SLOTS),
        .MAX_MESSAGE_BYTES (MAX_MESSAGE_BYTES),
        .OUT_DEPTH         (OUT_DEPTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_empty (cmd_empty),
        .i_cmd       (cmd_out),
        .o_cmd_pop   (cmd_pop),
        .i_out_count (out_count),
        .o_out_push  (out_push),
        .o_out       (out_in)
    );

    mqp_fifo #(
        .WIDTH ($bits(t_result)),
        .DEPTH (OUT_DEPTH)
    ) u_out_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (out_push),
        .i_data  (out_in),
        .o_full  (out_full),
        .i_pop   (pop),
        .o_data  (o_result),
        .o_empty (empty),
        .o_count (out_count)
    );

    a_no_push_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_push |-> !out_full)
        else $error("result queue overrun");

endmodule

### rtl/mqp_ram.sv
// Generic simple dual-port RAM with registered read.
module mqp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                        i_wdata,
    input  logic                                    i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                        o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/mqp_fifo.sv
// Register-based FIFO used between the front end, back end and result port.
module mqp_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_push,
    input  logic [WIDTH-1:0]             i_data,
    output logic                         o_full,
    input  logic                         i_pop,
    output logic [WIDTH-1:0]             o_data,
    output logic                         o_empty,
    output logic [$clog2(DEPTH+1)-1:0]   o_count
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr, n_wr;
    logic [AW-1:0]    r_rd, n_rd;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic             do_push, do_pop;

    assign o_full  = (r_cnt == CW'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_comb begin
        n_wr  = r_wr;
        n_rd  = r_rd;
        n_cnt = r_cnt;
        if (do_push) begin
            n_wr = (r_wr == AW'(DEPTH - 1)) ? '0 : AW'(r_wr + 1'b1);
        end
        if (do_pop) begin
            n_rd = (r_rd == AW'(DEPTH - 1)) ? '0 : AW'(r_rd + 1'b1);
        end
        if (do_push && !do_pop) begin
            n_cnt = CW'(r_cnt + 1'b1);
        end else if (do_pop && !do_push) begin
            n_cnt = CW'(r_cnt - 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            r_wr  <= n_wr;
            r_rd  <= n_rd;
            r_cnt <= n_cnt;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    assign o_data  = r_mem[r_rd];
    assign o_count = r_cnt;

endmodule

### rtl/mqp_front.sv
// Front end: accepts requests, tracks queue state and issues commands.
module mqp_front #(
    parameter int SLOTS             = mqp_pkg::SLOTS_DEF,
    parameter int MAX_MESSAGE_BYTES = mqp_pkg::MSG_BYTES_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  mqp_pkg::t_cfg_wr i_cfg,
    input  logic             i_push,
    input  mqp_pkg::t_item   i_item,
    input  logic             i_cmd_full,
    output logic             o_cmd_push,
    output mqp_pkg::t_cmd    o_cmd
);

    import mqp_pkg::*;

    localparam int SW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int MW  = SW + 1;
    localparam int WPS = (MAX_MESSAGE_BYTES + 3) / 4;
    localparam int IW  = $clog2(WPS + 1);

    function automatic logic [MW-1:0] eff_slots(input logic [CNT_W-1:0] v);
        logic [MW-1:0] r;
        if (v == '0) begin
            r = MW'(1);
        end else if (9'(v) > 9'(SLOTS)) begin
            r = MW'(SLOTS);
        end else begin
            r = MW'(v);
        end
        return r;
    endfunction

    function automatic logic [SW-1:0] wrap_inc(input logic [SW-1:0] idx,
                                               input logic [MW-1:0] m);
        logic [MW-1:0] inc;
        inc = MW'({1'b0, idx}) + MW'(1);
        return (inc == m) ? '0 : inc[SW-1:0];
    endfunction

    logic [CNT_W-1:0] r_max_msgs, n_max_msgs;
    logic [LEN_W-1:0] r_max_bytes, n_max_bytes;
    logic [SW-1:0]    r_head, n_head;
    logic [SW-1:0]    r_tail, n_tail;
    logic [CNT_W-1:0] r_count, n_count;
    logic             r_overflow, n_overflow;
    logic             r_wr_active, n_wr_active;
    logic             r_wr_discard, n_wr_discard;
    logic [IW-1:0]    r_wr_idx, n_wr_idx;
    logic [LEN_W-1:0] r_wr_len, n_wr_len;

    logic [MW-1:0]    m;
    logic [LEN_W-1:0] bmax;
    logic             accept;
    logic             disc;
    logic [STAT_W-1:0] st;
    logic [LEN_W-1:0] len_now;
    logic [IW-1:0]    idx_now;
    logic [SW-1:0]    slot_w;
    logic [7:0]       need;
    logic             store;
    t_cmd             cmd;

    always_comb begin
        m      = eff_slots(r_max_msgs);
        bmax   = (r_max_bytes > LEN_W'(MAX_MESSAGE_BYTES)) ?
                 LEN_W'(MAX_MESSAGE_BYTES) : r_max_bytes;
        accept = i_push && !i_cmd_full;

        n_max_msgs   = r_max_msgs;
        n_max_bytes  = r_max_bytes;
        n_head       = r_head;
        n_tail       = r_tail;
        n_count      = r_count;
        n_overflow   = r_overflow;
        n_wr_active  = r_wr_active;
        n_wr_discard = r_wr_discard;
        n_wr_idx     = r_wr_idx;
        n_wr_len     = r_wr_len;

        disc    = r_wr_discard;
        st      = ST_NO_ERROR;
        len_now = r_wr_len;
        idx_now = r_wr_idx;
        slot_w  = wrap_inc(r_tail, m);
        need    = '0;
        store   = 1'b0;
        cmd     = '0;

        if (accept) begin
            if (i_item.cmd == CMD_WRITE) begin
                if (!r_wr_active) begin
                    len_now = i_item.length_bytes;
                    idx_now = '0;
                    disc    = 1'b0;
                    if (i_item.length_bytes > bmax) begin
                        disc = 1'b1;
                        st   = ST_INVALID_CONFIG;
                    end else if (9'(r_count) >= 9'(m)) begin
                        disc       = 1'b1;
                        st         = ST_NOT_AVAILABLE;
                        n_overflow = 1'b1;
                    end
                end else if (r_wr_discard) begin
                    st = ST_NOT_AVAILABLE;
                end
                need  = 8'((10'(len_now) + 10'd3) >> 2);
                store = !disc && (8'(idx_now) < need);
                if (i_item.last_beat) begin
                    if (!disc) begin
                        n_tail  = slot_w;
                        n_count = CNT_W'(r_count + 1'b1);
                    end
                    n_wr_active  = 1'b0;
                    n_wr_discard = 1'b0;
                    n_wr_idx     = '0;
                    n_wr_len     = '0;
                end else begin
                    n_wr_active  = 1'b1;
                    n_wr_discard = disc;
                    n_wr_len     = len_now;
                    n_wr_idx     = store ? IW'(idx_now + 1'b1) : idx_now;
                end
                cmd.is_read    = 1'b0;
                cmd.store_word = store;
                cmd.store_len  = i_item.last_beat && !disc;
                cmd.slot       = SLOT_IDX_W'(slot_w);
                cmd.word_idx   = WORD_IDX_W'(idx_now);
                cmd.data       = i_item.data_word;
                cmd.length     = len_now;
                cmd.status     = st;
                cmd.count      = n_count;
            end else begin
                if (r_count == '0) begin
                    cmd.status = ST_NOT_AVAILABLE;
                    cmd.count  = '0;
                end else begin
                    n_head      = wrap_inc(r_head, m);
                    n_count     = CNT_W'(r_count - 1'b1);
                    n_overflow  = 1'b0;
                    cmd.is_read = 1'b1;
                    cmd.slot    = SLOT_IDX_W'(r_head);
                    cmd.status  = r_overflow ? ST_INVALID_CONFIG : ST_NO_ERROR;
                    cmd.count   = n_count;
                end
            end
        end

        if (i_cfg.valid) begin
            if (i_cfg.index == CFG_MAX_MESSAGES) begin
                n_max_msgs   = i_cfg.data[CNT_W-1:0];
                n_head       = '0;
                n_tail       = SW'(eff_slots(i_cfg.data[CNT_W-1:0]) - MW'(1));
                n_count      = '0;
                n_overflow   = 1'b0;
                n_wr_active  = 1'b0;
                n_wr_discard = 1'b0;
                n_wr_idx     = '0;
                n_wr_len     = '0;
            end else if (i_cfg.index == CFG_MAX_MESSAGE_BYTES) begin
                n_max_bytes = i_cfg.data[LEN_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_msgs   <= MAX_MESSAGES_RST;
            r_max_bytes  <= MAX_MESSAGE_BYTES_RST;
            r_head       <= '0;
            r_tail       <= SW'(eff_slots(MAX_MESSAGES_RST) - MW'(1));
            r_count      <= '0;
            r_overflow   <= 1'b0;
            r_wr_active  <= 1'b0;
            r_wr_discard <= 1'b0;
            r_wr_idx     <= '0;
            r_wr_len     <= '0;
        end else begin
            r_max_msgs   <= n_max_msgs;
            r_max_bytes  <= n_max_bytes;
            r_head       <= n_head;
            r_tail       <= n_tail;
            r_count      <= n_count;
            r_overflow   <= n_overflow;
            r_wr_active  <= n_wr_active;
            r_wr_discard <= n_wr_discard;
            r_wr_idx     <= n_wr_idx;
            r_wr_len     <= n_wr_len;
        end
    end

    assign o_cmd_push = accept;
    assign o_cmd      = cmd;

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        9'(r_count) <= 9'(m))
        else $error("message count exceeds slots in use");

    a_discard_in_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wr_discard |-> r_wr_active)
        else $error("discard flag set outside a write");

endmodule

### rtl/mqp_back.sv
// Back end: performs slot stores and streams messages into the result queue.
module mqp_back #(
    parameter int SLOTS             = mqp_pkg::SLOTS_DEF,
    parameter int MAX_MESSAGE_BYTES = mqp_pkg::MSG_BYTES_DEF,
    parameter int OUT_DEPTH         = mqp_pkg::OUT_DEPTH
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cmd_empty,
    input  mqp_pkg::t_cmd                  i_cmd,
    output logic                           o_cmd_pop,
    input  logic [$clog2(OUT_DEPTH+1)-1:0] i_out_count,
    output logic                           o_out_push,
    output mqp_pkg::t_result               o_out
);

    import mqp_pkg::*;

    localparam int SW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
    localparam int WPS = (MAX_MESSAGE_BYTES + 3) / 4;
    localparam int AW  = (WPS > 1) ? $clog2(WPS) : 1;
    localparam int NW  = $clog2(WPS + 1);
    localparam int OCW = $clog2(OUT_DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE   = 3'b001,
        S_LEN    = 3'b010,
        S_STREAM = 3'b100
    } t_bstate;

    t_bstate          r_state, n_state;
    logic [SW-1:0]    r_slot, n_slot;
    logic [STAT_W-1:0] r_final, n_final;
    logic [CNT_W-1:0] r_count, n_count;
    logic [LEN_W-1:0] r_len, n_len;
    logic [NW-1:0]    r_n, n_n;
    logic [NW-1:0]    r_issue, n_issue;
    logic [NW-1:0]    r_emit, n_emit;
    logic             r_inflight, n_inflight;

    logic             word_we, word_re, len_we, len_re;
    logic [WORD_W-1:0] word_rdata;
    logic [LEN_W-1:0] len_rdata;
    logic [7:0]       words;
    logic             room;
    logic             fin;

    mqp_ram #(
        .WIDTH (WORD_W),
        .DEPTH (2 ** (SW + AW))
    ) u_word_ram (
        .i_clk   (i_clk),
        .i_we    (word_we),
        .i_waddr ({i_cmd.slot[SW-1:0], i_cmd.word_idx[AW-1:0]}),
        .i_wdata (i_cmd.data),
        .i_re    (word_re),
        .i_raddr ({r_slot, r_issue[AW-1:0]}),
        .o_rdata (word_rdata)
    );

    mqp_ram #(
        .WIDTH (LEN_W),
        .DEPTH (2 ** SW)
    ) u_len_ram (
        .i_clk   (i_clk),
        .i_we    (len_we),
        .i_waddr (i_cmd.slot[SW-1:0]),
        .i_wdata (i_cmd.length),
        .i_re    (len_re),
        .i_raddr (i_cmd.slot[SW-1:0]),
        .o_rdata (len_rdata)
    );

    always_comb begin
        n_state    = r_state;
        n_slot     = r_slot;
        n_final    = r_final;
        n_count    = r_count;
        n_len      = r_len;
        n_n        = r_n;
        n_issue    = r_issue;
        n_emit     = r_emit;
        n_inflight = 1'b0;
        word_we    = 1'b0;
        word_re    = 1'b0;
        len_we     = 1'b0;
        len_re     = 1'b0;
        o_cmd_pop  = 1'b0;
        o_out_push = 1'b0;
        o_out      = '0;
        words      = 8'((10'(r_len) + 10'd3) >> 2);
        fin        = 1'b0;
        room = ((OCW + 1)'(i_out_count) + (OCW + 1)'(r_inflight)) < (OCW + 1)'(OUT_DEPTH);

        unique case (r_state)
            S_IDLE: begin
                if (!i_cmd_empty && (i_out_count < OCW'(OUT_DEPTH))) begin
                    o_cmd_pop = 1'b1;
                    if (i_cmd.is_read) begin
                        len_re  = 1'b1;
                        n_slot  = i_cmd.slot[SW-1:0];
                        n_final = i_cmd.status;
                        n_count = i_cmd.count;
                        n_state = S_LEN;
                    end else begin
                        word_we           = i_cmd.store_word;
                        len_we            = i_cmd.store_len;
                        o_out_push        = 1'b1;
                        o_out.status      = i_cmd.status;
                        o_out.last_result = 1'b1;
                        o_out.queue_count = i_cmd.count;
                    end
                end
            end
            S_LEN: begin
                n_len   = len_rdata;
                words   = 8'((10'(len_rdata) + 10'd3) >> 2);
                n_n     = (len_rdata == '0) ? NW'(1) : NW'(words);
                n_issue = '0;
                n_emit  = '0;
                n_state = S_STREAM;
            end
            S_STREAM: begin
                if ((r_issue < r_n) && room) begin
                    word_re    = 1'b1;
                    n_issue    = NW'(r_issue + 1'b1);
                    n_inflight = 1'b1;
                end
                if (r_inflight) begin
                    fin               = (NW'(r_emit + 1'b1) == r_n);
                    o_out_push        = 1'b1;
                    o_out.status      = fin ? r_final : ST_NO_ERROR;
                    o_out.read_word   = (r_len == '0) ? '0 : word_rdata;
                    o_out.read_length = r_len;
                    o_out.last_result = fin;
                    o_out.queue_count = r_count;
                    n_emit            = NW'(r_emit + 1'b1);
                    if (fin) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_issue    <= '0;
            r_emit     <= '0;
            r_n        <= '0;
            r_inflight <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_issue    <= n_issue;
            r_emit     <= n_emit;
            r_n        <= n_n;
            r_inflight <= n_inflight;
        end
    end

    always_ff @(posedge i_clk) begin
        r_slot  <= n_slot;
        r_final <= n_final;
        r_count <= n_count;
        r_len   <= n_len;
    end

    a_push_has_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_push |-> (i_out_count < OCW'(OUT_DEPTH)))
        else $error("result pushed into a full queue");

    a_emit_behind_issue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_STREAM) |-> ((r_emit <= r_issue) && (r_issue <= r_n)))
        else $error("word stream counters out of order");

    a_read_enters_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd_pop && i_cmd.is_read) |=> (r_state == S_LEN))
        else $error("read command did not start a length fetch");

endmodule

### tb/sv/tb_top.sv
// Self-checking testbench for the message queue port: directed table, then random traffic.
module tb_top;
    import mqp_pkg::*;

    localparam int WORDS_PER_SLOT = (MSG_BYTES_DEF + 3) / 4;
    localparam int QUIET_LIMIT    = 2000;
    localparam int RANDOM_ITEMS   = 320;
    localparam int PHASE_ITEMS    = 45;
    localparam int FIXED_PHASES   = 7;
    localparam int PHASE_SLOTS [FIXED_PHASES] = '{16, 1, 31, 0, 2, 3, 16};
    localparam int PHASE_BYTES [FIXED_PHASES] = '{256, 256, 511, 0, 8, 1, 256};

    typedef enum {ROW_ITEM, ROW_CFG} t_row_kind;

    typedef struct {
        t_row_kind             kind;
        logic [CFG_IDX_W-1:0]  idx;
        logic [CFG_DATA_W-1:0] data;
        t_item                 item;
        bit                    typed;
        t_result               want;
    } t_stim_row;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n;
    logic                  push;
    t_item                 i_item;
    logic                  full;
    logic                  empty;
    logic                  pop = 1'b0;
    t_result               o_result;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    message_queue_port u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .push        (push),
        .i_item      (i_item),
        .full        (full),
        .empty       (empty),
        .pop         (pop),
        .o_result    (o_result),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always #5 i_clk = ~i_clk;

    // Predicted ring contents and pointers
    logic [WORD_W-1:0] ring_words [SLOTS_DEF][WORDS_PER_SLOT];
    bit                word_seen  [SLOTS_DEF][WORDS_PER_SLOT];
    int                ring_len   [SLOTS_DEF];
    int                q_head;
    int                q_tail;
    int                q_count;
    bit                q_ovf;
    bit                wr_busy;
    bit                wr_drop;
    int                wr_idx;
    int                wr_len;
    int                reg_slots;
    int                reg_bytes;

    t_result   pending_results [$];
    t_stim_row stim_rows [$];
    t_result   mon_want;
    int        errors = 0;
    int        sent = 0;
    int        burst_left = 0;
    int        quiet_cycles = 0;
    logic [15:0] stall_pat = 16'hFFFF;
    int        pat_left = 0;

    function automatic int slots_used();
        int v;
        v = reg_slots;
        if (v < 1) v = 1;
        if (v > SLOTS_DEF) v = SLOTS_DEF;
        return v;
    endfunction

    function automatic int bytes_cap();
        return (reg_bytes > MSG_BYTES_DEF) ? MSG_BYTES_DEF : reg_bytes;
    endfunction

    task automatic clear_ring();
        q_head  = 0;
        q_tail  = slots_used() - 1;
        q_count = 0;
        q_ovf   = 1'b0;
        wr_busy = 1'b0;
        wr_drop = 1'b0;
        wr_idx  = 0;
        wr_len  = 0;
    endtask

    task automatic apply_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        if (idx == CFG_MAX_MESSAGES) begin
            reg_slots = data[CNT_W-1:0];
            clear_ring();
        end else if (idx == CFG_MAX_MESSAGE_BYTES) begin
            reg_bytes = data;
        end
    endtask

    task automatic queue_step(input t_item it);
        int                m;
        int                slot;
        int                need;
        int                n;
        int                len;
        logic [STAT_W-1:0] st;
        logic [STAT_W-1:0] st_fin;
        t_result           r;
        m = slots_used();
        r = '0;
        r.last_result = 1'b1;
        if (it.cmd == CMD_WRITE) begin
            st = ST_NO_ERROR;
            if (!wr_busy) begin
                wr_busy = 1'b1;
                wr_drop = 1'b0;
                wr_idx  = 0;
                wr_len  = it.length_bytes;
                if (it.length_bytes > bytes_cap()) begin
                    wr_drop = 1'b1;
                    st = ST_INVALID_CONFIG;
                end else if (q_count >= m) begin
                    q_ovf   = 1'b1;
                    wr_drop = 1'b1;
                    st = ST_NOT_AVAILABLE;
                end
            end else if (wr_drop) begin
                st = ST_NOT_AVAILABLE;
            end
            if (!wr_drop) begin
                slot = (q_tail + 1) % m;
                need = (wr_len + 3) / 4;
                if (wr_idx < need && wr_idx < WORDS_PER_SLOT) begin
                    ring_words[slot][wr_idx] = it.data_word;
                    word_seen[slot][wr_idx]  = 1'b1;
                    wr_idx++;
                end
                if (it.last_beat) begin
                    ring_len[slot] = wr_len;
                    q_tail = slot;
                    q_count++;
                end
            end
            if (it.last_beat) begin
                wr_busy = 1'b0;
                wr_drop = 1'b0;
                wr_idx  = 0;
                wr_len  = 0;
            end
            r.status      = st;
            r.queue_count = q_count;
            pending_results.push_back(r);
        end else if (q_count == 0) begin
            r.status = ST_NOT_AVAILABLE;
            pending_results.push_back(r);
        end else begin
            slot = q_head % m;
            len  = ring_len[slot];
            n    = (len + 3) / 4;
            if (n > WORDS_PER_SLOT) n = WORDS_PER_SLOT;
            if (n == 0) n = 1;
            q_head = (slot + 1) % m;
            q_count--;
            st_fin = q_ovf ? ST_INVALID_CONFIG : ST_NO_ERROR;
            q_ovf  = 1'b0;
            for (int i = 0; i < n; i++) begin
                r.status      = (i + 1 == n) ? st_fin : ST_NO_ERROR;
                r.read_word   = (len == 0) ? '0 : ring_words[slot][i];
                r.read_length = len;
                r.last_result = (i + 1 == n);
                r.queue_count = q_count;
                pending_results.push_back(r);
            end
        end
    endtask

    // Present one request, hold it until taken, then pause between bursts
    task automatic send_item(input t_item it, input bit typed, input t_result want);
        int gap;
        @(negedge i_clk);
        push   <= 1'b1;
        i_item <= it;
        do @(posedge i_clk); while (full);
        sent++;
        queue_step(it);
        if (typed) pending_results[pending_results.size() - 1] = want;
        if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(30, 60)
                                                     : $urandom_range(1, 12);
            gap = $urandom_range(1, 6);
            @(negedge i_clk) push <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    // Drain all results, then write one register
    task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                  input logic [CFG_DATA_W-1:0] data);
        @(negedge i_clk) push <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        apply_register(idx, data);
        @(negedge i_clk) i_cfg_valid <= 1'b0;
    endtask

    function automatic t_result plain_result(input logic [STAT_W-1:0] st, input int cnt);
        t_result r;
        r = '0;
        r.status      = st;
        r.last_result = 1'b1;
        r.queue_count = cnt;
        return r;
    endfunction

    task automatic add_item(input logic cmd, input logic [LEN_W-1:0] len,
                            input logic [WORD_W-1:0] data, input logic last,
                            input bit typed, input logic [STAT_W-1:0] st, input int cnt);
        t_stim_row row;
        row.kind  = ROW_ITEM;
        row.idx   = '0;
        row.data  = '0;
        row.item.cmd          = cmd;
        row.item.length_bytes = len;
        row.item.data_word    = data;
        row.item.last_beat    = last;
        row.typed = typed;
        row.want  = plain_result(st, cnt);
        stim_rows.push_back(row);
    endtask

    task automatic add_cfg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] data);
        t_stim_row row;
        row.kind  = ROW_CFG;
        row.idx   = idx;
        row.data  = data;
        row.item  = '0;
        row.typed = 1'b0;
        row.want  = '0;
        stim_rows.push_back(row);
    endtask

    function automatic logic [WORD_W-1:0] rand_word();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    function automatic t_item rand_read();
        t_item it;
        it.cmd          = CMD_READ;
        it.length_bytes = LEN_W'($urandom);
        it.data_word    = $urandom;
        it.last_beat    = $urandom_range(0, 1);
        return it;
    endfunction

    function automatic int pick_len();
        int r;
        if ($urandom_range(0, 3) == 0) return $urandom_range(0, bytes_cap());
        r = $urandom_range(0, 19);
        if (r < 12) return $urandom_range(0, 16);
        if (r < 16) return $urandom_range(17, 64);
        if (r == 16) return $urandom_range(65, 256);
        if (r == 17) return 256;
        return $urandom_range(bytes_cap() + 1, 511);
    endfunction

    // Send one whole message; a short one only leaves words that the slot already holds
    task automatic send_message(input int len);
        int    m;
        int    slot;
        int    need;
        int    base;
        int    kmin;
        int    beats;
        int    split;
        int    pick;
        bit    kept;
        t_item it;
        m    = slots_used();
        kept = !wr_busy && len <= bytes_cap() && q_count < m;
        if (kept) begin
            slot = (q_tail + 1) % m;
            need = (len + 3) / 4;
            base = (need > 0) ? need : 1;
            kmin = 1;
            for (int w = 0; w < need; w++) begin
                if (!word_seen[slot][w]) kmin = w + 1;
            end
            pick = $urandom_range(0, 9);
            if (pick < 6) beats = base;
            else if (pick < 8) beats = $urandom_range(kmin, base);
            else beats = base + $urandom_range(1, 3);
        end else begin
            beats = $urandom_range(1, 5);
        end
        split = (beats > 1 && $urandom_range(0, 9) == 0) ? $urandom_range(1, beats - 1) : 0;
        for (int i = 0; i < beats; i++) begin
            if (split != 0 && i == split) send_item(rand_read(), 1'b0, '0);
            it.cmd          = CMD_WRITE;
            it.length_bytes = (i == 0) ? LEN_W'(len) : LEN_W'($urandom);
            it.data_word    = rand_word();
            it.last_beat    = (i == beats - 1);
            send_item(it, 1'b0, '0);
        end
    endtask

    always @(negedge i_clk) begin
        if (pat_left == 0) begin
            pat_left  = $urandom_range(20, 80);
            stall_pat = ($urandom_range(0, 3) == 0) ? 16'hFFFF
                                                    : (16'($urandom) | 16'h0001);
        end else begin
            pat_left--;
        end
        stall_pat = {stall_pat[0], stall_pat[15:1]};
        pop <= stall_pat[0];
    end

    always @(posedge i_clk) begin
        if (i_rst_n && pop && !empty) begin
            if (pending_results.size() == 0) begin
                $write("%0t: unexpected result: expected none, ", $time);
                $display("got status=%0d word=%h length=%0d last=%0d count=%0d",
                         o_result.status, o_result.read_word, o_result.read_length,
                         o_result.last_result, o_result.queue_count);
                errors++;
            end else begin
                mon_want = pending_results.pop_front();
                if (o_result !== mon_want) begin
                    $write("%0t: result mismatch: expected status=%0d word=%h length=%0d",
                           $time, mon_want.status, mon_want.read_word,
                           mon_want.read_length);
                    $write(" last=%0d count=%0d, ",
                           mon_want.last_result, mon_want.queue_count);
                    $display("got status=%0d word=%h length=%0d last=%0d count=%0d",
                             o_result.status, o_result.read_word, o_result.read_length,
                             o_result.last_result, o_result.queue_count);
                    errors++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (push && !full) || (pop && !empty) || (i_cfg_valid && o_cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles = quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
            $display("message_queue_port test failed");
            $finish;
        end
    end

    initial begin
        int    rand_start;
        int    phase_start;
        int    phase;
        int    wr_pct;
        int    s;
        int    b;
        t_item it;
        i_rst_n     = 1'b0;
        push        = 1'b0;
        i_item      = '0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data  = '0;
        reg_slots   = MAX_MESSAGES_RST;
        reg_bytes   = MAX_MESSAGE_BYTES_RST;
        clear_ring();

        add_item(CMD_READ,  9'd0,   32'h0,         1'b0, 1, ST_NOT_AVAILABLE,  0);
        add_item(CMD_WRITE, 9'd257, 32'h0,         1'b1, 1, ST_INVALID_CONFIG, 0);
        add_item(CMD_WRITE, 9'd511, 32'hFFFF_FFFF, 1'b1, 1, ST_INVALID_CONFIG, 0);
        add_item(CMD_WRITE, 9'd0,   32'h0,         1'b1, 1, ST_NO_ERROR,       1);
        add_item(CMD_READ,  9'd511, 32'hFFFF_FFFF, 1'b1, 1, ST_NO_ERROR,       0);
        add_item(CMD_WRITE, 9'd8,   32'h0,         1'b0, 1, ST_NO_ERROR,       0);
        add_item(CMD_WRITE, 9'h1FF, 32'hFFFF_FFFF, 1'b1, 1, ST_NO_ERROR,       1);
        add_item(CMD_WRITE, 9'd4,   32'h1234_5678, 1'b0, 1, ST_NO_ERROR,       1);
        add_item(CMD_READ,  9'd0,   32'h0,         1'b0, 0, ST_NO_ERROR,       0);
        add_item(CMD_WRITE, 9'd4,   32'hDEAD_BEEF, 1'b1, 1, ST_NO_ERROR,       1);
        add_item(CMD_READ,  9'd0,   32'h0,         1'b0, 0, ST_NO_ERROR,       0);
        add_cfg(CFG_MAX_MESSAGES, 9'd1);
        add_item(CMD_WRITE, 9'd8,   32'hA5A5_A5A5, 1'b0, 1, ST_NO_ERROR,       0);
        add_item(CMD_WRITE, 9'd0,   32'h5A5A_5A5A, 1'b1, 1, ST_NO_ERROR,       1);
        add_item(CMD_WRITE, 9'd4,   32'h0,         1'b1, 1, ST_NOT_AVAILABLE,  1);
        add_item(CMD_READ,  9'd0,   32'h0,         1'b0, 0, ST_NO_ERROR,       0);
        add_item(CMD_WRITE, 9'd8,   32'h0F0F_0F0F, 1'b1, 1, ST_NO_ERROR,       1);
        add_item(CMD_READ,  9'd0,   32'h0,         1'b0, 0, ST_NO_ERROR,       0);
        add_item(CMD_READ,  9'd0,   32'h0,         1'b1, 1, ST_NOT_AVAILABLE,  0);
        add_cfg(CFG_MAX_MESSAGE_BYTES, 9'd0);
        add_item(CMD_WRITE, 9'd1,   32'h0,         1'b1, 1, ST_INVALID_CONFIG, 0);
        add_item(CMD_WRITE, 9'd0,   32'h8000_0001, 1'b1, 1, ST_NO_ERROR,       1);
        add_cfg(CFG_MAX_MESSAGE_BYTES, 9'd511);
        add_item(CMD_WRITE, 9'd257, 32'h0,         1'b1, 1, ST_INVALID_CONFIG, 1);
        add_item(CMD_READ,  9'd0,   32'h0,         1'b0, 0, ST_NO_ERROR,       0);
        add_item(CMD_WRITE, 9'd4,   32'h3C3C_3C3C, 1'b0, 1, ST_NO_ERROR,       0);
        add_cfg(CFG_MAX_MESSAGES, 9'd0);
        add_item(CMD_WRITE, 9'd4,   32'hC3C3_C3C3, 1'b1, 1, ST_NO_ERROR,       1);
        add_item(CMD_READ,  9'd0,   32'h0,         1'b0, 0, ST_NO_ERROR,       0);
        add_cfg(CFG_MAX_MESSAGES, 9'd16);
        add_cfg(CFG_MAX_MESSAGE_BYTES, 9'd256);

        repeat (11) @(posedge i_clk);
        @(negedge i_clk) i_rst_n <= 1'b1;

        foreach (stim_rows[k]) begin
            if (stim_rows[k].kind == ROW_CFG)
                write_register(stim_rows[k].idx, stim_rows[k].data);
            else
                send_item(stim_rows[k].item, stim_rows[k].typed, stim_rows[k].want);
        end

        rand_start = sent;
        phase = 0;
        while (sent - rand_start < RANDOM_ITEMS) begin
            if (phase < FIXED_PHASES) begin
                s = PHASE_SLOTS[phase];
                b = PHASE_BYTES[phase];
            end else begin
                s = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31)
                                                : $urandom_range(1, 16);
                b = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 511)
                                                : $urandom_range(4, 80);
            end
            write_register(CFG_MAX_MESSAGES, CFG_DATA_W'(s));
            write_register(CFG_MAX_MESSAGE_BYTES, CFG_DATA_W'(b));
            wr_pct = $urandom_range(35, 75);
            phase_start = sent;
            while (sent - phase_start < PHASE_ITEMS) begin
                if ($urandom_range(0, 99) < wr_pct)
                    send_message(pick_len());
                else
                    send_item(rand_read(), 1'b0, '0);
            end
            // leave a message unfinished for the next register write to abandon
            if ($urandom_range(0, 2) == 0) begin
                it.cmd          = CMD_WRITE;
                it.length_bytes = LEN_W'(pick_len());
                it.data_word    = rand_word();
                it.last_beat    = 1'b0;
                send_item(it, 1'b0, '0);
            end
            phase++;
        end

        @(negedge i_clk) push <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (errors == 0)
            $display("message_queue_port test passed");
        else
            $display("message_queue_port test failed");
        $finish;
    end

endmodule
